// ===== hw/rtl/ima_dec_pkg.sv =====
`timescale 1ns / 1ps

package ima_dec_pkg;

    localparam logic [6:0] IDX_MAX = 7'd88;

    localparam logic [14:0] STEP_TAB [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
        15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
        15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
        15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
        15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
        15'd32767
    };

    localparam logic signed [7:0] IDX_ADJ [0:7] = '{
        -8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
    };

    localparam logic signed [17:0] SUM_MIN = -18'sd32768;
    localparam logic signed [17:0] SUM_MAX = 18'sd32767;

    typedef struct packed {
        logic signed [15:0] pred;
        logic [6:0]         idx;
    } t_nib;

    // One IMA code step: predictor and step index update, both clamped.
    function automatic t_nib nib_step(input logic signed [15:0] pred,
                                      input logic [6:0] idx,
                                      input logic [3:0] code);
        logic [6:0]         si;
        logic [14:0]        step;
        logic [16:0]        dlt;
        logic signed [17:0] sum;
        logic signed [7:0]  ni;
        t_nib               res;
        si   = (idx > IDX_MAX) ? IDX_MAX : idx;
        step = STEP_TAB[si];
        dlt  = {5'b0, step[14:3]};
        if (code[0]) dlt = dlt + {4'b0, step[14:2]};
        if (code[1]) dlt = dlt + {3'b0, step[14:1]};
        if (code[2]) dlt = dlt + {2'b0, step};
        if (code[3]) sum = {{2{pred[15]}}, pred} - $signed({1'b0, dlt});
        else         sum = {{2{pred[15]}}, pred} + $signed({1'b0, dlt});
        if (sum < SUM_MIN)      res.pred = 16'sh8000;
        else if (sum > SUM_MAX) res.pred = 16'sh7FFF;
        else                    res.pred = sum[15:0];
        ni = $signed({1'b0, si}) + IDX_ADJ[code[2:0]];
        if (ni < 8'sd0)                        res.idx = 7'd0;
        else if (ni > $signed({1'b0, IDX_MAX})) res.idx = IDX_MAX;
        else                                   res.idx = ni[6:0];
        return res;
    endfunction

endpackage

// ===== hw/rtl/ima_adpcm_block_decoder_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Signals                                   | Accepted when
// --------+-----------+-------------------------------------------+------------------------
// in      | to unit   | i_in_valid, o_in_ready, i_code_byte       | i_in_valid & o_in_ready
// out     | from unit | o_out_valid, i_out_ready, o_pcm_sample,   | o_out_valid & i_out_ready
//         |           | o_channel_id, o_block_first,              |
//         |           | o_header_bad, o_run_last                  |
// cfg     | to unit   | i_cfg_valid, o_cfg_ready, i_cfg_index,    | i_cfg_valid & o_cfg_ready
//         |           | i_cfg_data                                |
//
// A byte is decoded in the cycle it is accepted; its 0 to 4 samples sit in a
// four-entry result buffer and leave from the next cycle on, one per cycle
// while the sink is ready. With a ready sink the result buffer drain sets the
// byte rate (samples: mono data 2, stereo right byte 4, header/left byte 0 or 1).
// The next byte is taken in the cycle the last buffered sample is taken.
// Synchronous active-low reset: mono, 1024-byte blocks, start of block.
// Config writes are always taken and apply from the next byte.

module ima_adpcm_block_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_code_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_pcm_sample,
    output logic               o_channel_id,
    output logic               o_block_first,
    output logic               o_header_bad,
    output logic               o_run_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import ima_dec_pkg::*;

    localparam logic [1:0] CFG_CHAN = 2'd0;
    localparam logic [1:0] CFG_BLK  = 2'd1;

    // configuration
    logic [1:0]  r_chan, n_chan;
    logic [15:0] r_blk,  n_blk;

    // decoder state
    logic signed [15:0] r_pred [2];
    logic signed [15:0] n_pred [2];
    logic [6:0]         r_idx  [2];
    logic [6:0]         n_idx  [2];
    logic [31:0]        r_held [4];  // left sample pairs, {high nibble, low nibble}
    logic [31:0]        n_held [4];
    logic [15:0]        r_pos, n_pos;
    logic [7:0]         r_hlow, n_hlow;
    logic               r_bad, n_bad;

    // result buffer
    logic [2:0]         r_cnt, n_cnt;
    logic [1:0]         r_rd,  n_rd;
    logic signed [15:0] r_smp [4];
    logic signed [15:0] n_smp [4];
    logic [3:0]         r_chv, n_chv;
    logic               r_first, n_first;
    logic               r_obad,  n_obad;

    logic        in_acc, out_acc;
    logic        stereo, blk_ok, bad_cur, hch;
    logic [15:0] hdr, dpos, lim;
    logic [16:0] pos_inc;
    logic [1:0]  grp;
    t_nib        dec_l0, dec_l1, dec_r0, dec_r1;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_out_ready);
    assign o_out_valid = (r_cnt != 3'd0);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    assign o_pcm_sample  = r_smp[r_rd];
    assign o_channel_id  = r_chv[r_rd];
    assign o_block_first = r_first;
    assign o_header_bad  = r_obad;
    assign o_run_last    = (r_cnt == 3'd1);

    assign stereo  = (r_chan == 2'd2);
    assign hdr     = stereo ? 16'd8 : 16'd4;
    assign blk_ok  = (r_blk >= hdr);
    assign bad_cur = (r_pos == 16'd0) ? 1'b0 : r_bad;
    assign hch     = r_pos[2];
    assign dpos    = r_pos - hdr;
    // whole groups only: (block - hdr) rounded down to a multiple of hdr
    assign lim     = (r_blk - hdr) & (stereo ? 16'hFFF8 : 16'hFFFC);
    assign grp     = dpos[1:0];
    assign pos_inc = {1'b0, r_pos} + 17'd1;

    // two chained code steps per channel
    assign dec_l0 = nib_step(r_pred[0], r_idx[0], i_code_byte[3:0]);
    assign dec_l1 = nib_step(dec_l0.pred, dec_l0.idx, i_code_byte[7:4]);
    assign dec_r0 = nib_step(r_pred[1], r_idx[1], i_code_byte[3:0]);
    assign dec_r1 = nib_step(dec_r0.pred, dec_r0.idx, i_code_byte[7:4]);

    always_comb begin
        n_chan  = r_chan;
        n_blk   = r_blk;
        n_pred  = r_pred;
        n_idx   = r_idx;
        n_held  = r_held;
        n_pos   = r_pos;
        n_hlow  = r_hlow;
        n_bad   = r_bad;
        n_cnt   = r_cnt;
        n_rd    = r_rd;
        n_smp   = r_smp;
        n_chv   = r_chv;
        n_first = r_first;
        n_obad  = r_obad;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHAN: n_chan = i_cfg_data[1:0];
                CFG_BLK:  n_blk  = i_cfg_data;
                default:  ;
            endcase
        end

        if (out_acc) begin
            n_cnt = r_cnt - 3'd1;
            n_rd  = r_rd + 2'd1;
        end

        if (in_acc) begin
            n_bad   = bad_cur;
            n_cnt   = 3'd0;
            n_rd    = 2'd0;
            n_first = 1'b0;
            n_obad  = bad_cur;
            n_smp   = '{default: 16'sd0};
            n_chv   = 4'b0000;
            if (blk_ok) begin
                if (r_pos < hdr) begin
                    case (r_pos[1:0])
                        2'd0: n_hlow = i_code_byte;
                        2'd1: begin
                            n_pred[hch] = {i_code_byte, r_hlow};
                            n_smp[0]    = bad_cur ? 16'sd0 : $signed({i_code_byte, r_hlow});
                            n_chv[0]    = hch;
                            n_first     = 1'b1;
                            n_cnt       = 3'd1;
                        end
                        2'd2: begin
                            if (i_code_byte > {1'b0, IDX_MAX}) begin
                                n_bad       = 1'b1;
                                n_idx[hch]  = IDX_MAX;
                            end else begin
                                n_idx[hch]  = i_code_byte[6:0];
                            end
                        end
                        default: begin
                            if (i_code_byte != 8'd0) n_bad = 1'b1;
                        end
                    endcase
                end else if (dpos < lim) begin
                    if (!stereo) begin
                        n_cnt = 3'd2;
                        if (!bad_cur) begin
                            n_pred[0] = dec_l1.pred;
                            n_idx[0]  = dec_l1.idx;
                            n_smp[0]  = dec_l0.pred;
                            n_smp[1]  = dec_l1.pred;
                        end
                    end else if (!dpos[2]) begin
                        // left byte: hold both samples until its right byte
                        if (!bad_cur) begin
                            n_pred[0]   = dec_l1.pred;
                            n_idx[0]    = dec_l1.idx;
                            n_held[grp] = {dec_l1.pred, dec_l0.pred};
                        end
                    end else begin
                        n_cnt = 3'd4;
                        n_chv = 4'b1010;
                        if (!bad_cur) begin
                            n_pred[1] = dec_r1.pred;
                            n_idx[1]  = dec_r1.idx;
                            n_smp[0]  = r_held[grp][15:0];
                            n_smp[1]  = dec_r0.pred;
                            n_smp[2]  = r_held[grp][31:16];
                            n_smp[3]  = dec_r1.pred;
                        end
                    end
                end
            end
            if (pos_inc >= {1'b0, r_blk}) n_pos = 16'd0;
            else                          n_pos = pos_inc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 2'd1;
            r_blk  <= 16'd1024;
            r_pred <= '{default: 16'sd0};
            r_idx  <= '{default: 7'd0};
            r_held <= '{default: 32'd0};
            r_pos  <= 16'd0;
            r_hlow <= 8'd0;
            r_bad  <= 1'b0;
            r_cnt  <= 3'd0;
            r_rd   <= 2'd0;
        end else begin
            r_chan <= n_chan;
            r_blk  <= n_blk;
            r_pred <= n_pred;
            r_idx  <= n_idx;
            r_held <= n_held;
            r_pos  <= n_pos;
            r_hlow <= n_hlow;
            r_bad  <= n_bad;
            r_cnt  <= n_cnt;
            r_rd   <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp   <= n_smp;
        r_chv   <= n_chv;
        r_first <= n_first;
        r_obad  <= n_obad;
    end

    // buffer never holds more than one byte's worth of samples
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result buffer overfilled");

    // predictor high byte of a header yields a block_first sample next cycle
    a_hdr_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && blk_ok && (r_pos < hdr) && (r_pos[1:0] == 2'd1))
        |=> (o_out_valid && o_block_first && o_run_last))
        else $error("header sample missing");

    // a failed header forces zero samples
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_header_bad) |-> (o_pcm_sample == 16'sd0))
        else $error("bad block sample not zero");

endmodule
